// ===== hw/rtl/btc_pkg.sv =====
`default_nettype none
package btc_pkg;

  localparam int COLUMN_LIMIT = 32;
  localparam int COL_W        = 7;
  localparam int CNT_W        = 7;
  localparam int MASK_W       = 64;
  localparam int MASK_IDX_W   = $clog2(MASK_W);
  localparam int FIFO_DEPTH   = 4;

  localparam logic [MASK_W-1:0] TAB_STOP_RESET = 64'h1111_1111_1111_1110;

  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic {
    OP_TEXT  = 1'b0,
    OP_FLUSH = 1'b1
  } btc_op_t;

  typedef struct packed {
    btc_op_t    op;
    logic [7:0] data_byte;
  } btc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } btc_out_t;

  // one queued run: tabs, then blanks, then an optional byte
  typedef struct packed {
    logic [CNT_W-1:0] tabs;
    logic [CNT_W-1:0] blanks;
    logic             has_byte;
    logic [7:0]       data;
  } btc_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/blank_run_to_tab_compressor.sv =====
// Blank run to tab compressor (entab with a programmable tab stop list).
// Input queue port: in_item (op, data_byte) is taken when in_push is high
//   and in_full is low. op selects a text byte or an end-of-input flush.
// Output queue port: out_item (out_byte, last) is valid while out_empty is
//   low and is taken when out_pop is high; last marks the final byte that
//   one input item produced. Items that produce nothing show no output.
// Config: cfg_we writes cfg_data into the 64-bit tab stop mask (bit p set
//   means 1-based column p is a stop); write only while the block is idle.
// Path: an item is written into the command queue at the edge that takes
//   it and is loaded into the expander register once that is free; the
//   first output byte of the item is shown from that register.
// Throughput: one item per cycle while out_pop stays high and each item
//   yields at most one byte. An item that releases a run of N tabs and
//   blanks plus a byte holds the expander until all N+1 bytes are taken;
//   a 4-entry command queue decouples the front; in_full rises when full.
// Reset: column and pending counts clear, the mask returns to a stop every
//   4th column, queue and output are empty.
// Output stall: the shown byte holds; the queue fills, then in_full rises.
`default_nettype none
module blank_run_to_tab_compressor import btc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire btc_in_t           in_item,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output btc_out_t               out_item,
  input  wire logic              cfg_we,
  input  wire logic [MASK_W-1:0] cfg_data
);

  logic     accept;
  logic     cmd_push;
  btc_cmd_t cmd_in;
  btc_cmd_t cmd_out;
  logic     cmd_empty;
  logic     cmd_pop;

  assign accept = in_push && !in_full;

  btc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  btc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (in_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  btc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/btc_front.sv =====
`default_nettype none
module btc_front import btc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [MASK_W-1:0] cfg_data,
  input  wire logic              accept,
  input  wire btc_in_t           item,
  output logic                   cmd_push,
  output btc_cmd_t               cmd
);

  logic [MASK_W-1:0] mask_r;
  logic [COL_W-1:0]  column_r, column_nxt;
  logic [CNT_W-1:0]  tabs_r, tabs_nxt;
  logic [CNT_W-1:0]  blanks_r, blanks_nxt;

  logic [COL_W-1:0]      pos;
  logic [MASK_W-1:0]     cand;
  logic [MASK_W-1:0]     first;
  logic [MASK_IDX_W-1:0] stop_idx;
  logic                  stop_found;
  logic                  held_blank;

  assign pos        = column_r + COL_W'(1);
  assign held_blank = (item.data_byte == CH_BLANK) && (pos < COL_W'(COLUMN_LIMIT));

  // next tab stop strictly right of the current column
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      cand[i] = mask_r[i] && (i < COLUMN_LIMIT) && (MASK_IDX_W'(i) >= pos[MASK_IDX_W-1:0])
                && (pos < COL_W'(MASK_W));
    end
    first    = cand & (~cand + MASK_W'(1));
    stop_idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (first[i]) begin
        stop_idx = stop_idx | MASK_IDX_W'(i);
      end
    end
    stop_found = |cand;
  end

  always_comb begin
    column_nxt    = column_r;
    tabs_nxt      = tabs_r;
    blanks_nxt    = blanks_r;
    cmd_push      = 1'b0;
    cmd.tabs      = tabs_r;
    cmd.blanks    = blanks_r;
    cmd.has_byte  = 1'b0;
    cmd.data      = item.data_byte;
    if (accept) begin
      if (item.op == OP_FLUSH) begin
        cmd_push   = (tabs_r != '0) || (blanks_r != '0);
        tabs_nxt   = '0;
        blanks_nxt = '0;
        column_nxt = '0;
      end else if (held_blank) begin
        if (mask_r[pos[MASK_IDX_W-1:0]]) begin
          tabs_nxt   = tabs_r + CNT_W'(1);
          blanks_nxt = '0;
        end else begin
          blanks_nxt = blanks_r + CNT_W'(1);
        end
        column_nxt = pos;
      end else if (item.data_byte == CH_TAB) begin
        cmd_push     = 1'b1;
        cmd.blanks   = '0;
        cmd.has_byte = 1'b1;
        tabs_nxt     = '0;
        blanks_nxt   = '0;
        column_nxt   = stop_found ? COL_W'(stop_idx) : COL_W'(COLUMN_LIMIT);
      end else begin
        cmd_push     = 1'b1;
        cmd.has_byte = 1'b1;
        tabs_nxt     = '0;
        blanks_nxt   = '0;
        if (item.data_byte == CH_NEWLINE) begin
          column_nxt = '0;
        end else if (column_r >= COL_W'(COLUMN_LIMIT)) begin
          column_nxt = COL_W'(COLUMN_LIMIT);
        end else begin
          column_nxt = pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= TAB_STOP_RESET;
      column_r <= '0;
      tabs_r   <= '0;
      blanks_r <= '0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_data;
      end
      column_r <= column_nxt;
      tabs_r   <= tabs_nxt;
      blanks_r <= blanks_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btc_fifo.sv =====
`default_nettype none
module btc_fifo import btc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire btc_cmd_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output btc_cmd_t      rd_data,
  output logic          empty
);

  localparam int AW = $clog2(FIFO_DEPTH);

  btc_cmd_t        mem [FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btc_back.sv =====
`default_nettype none
module btc_back import btc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire btc_cmd_t cmd,
  input  wire logic     cmd_empty,
  output logic          cmd_pop,
  output logic          out_empty,
  input  wire logic     out_pop,
  output btc_out_t      out_item
);

  btc_cmd_t work_r, work_nxt;
  logic     valid_r, valid_nxt;
  logic     last;
  logic     take;

  always_comb begin
    last = (work_r.tabs == CNT_W'(1) && work_r.blanks == '0 && !work_r.has_byte)
        || (work_r.tabs == '0 && work_r.blanks == CNT_W'(1) && !work_r.has_byte)
        || (work_r.tabs == '0 && work_r.blanks == '0 && work_r.has_byte);
    if (work_r.tabs != '0) begin
      out_item.out_byte = CH_TAB;
    end else if (work_r.blanks != '0) begin
      out_item.out_byte = CH_BLANK;
    end else begin
      out_item.out_byte = work_r.data;
    end
    out_item.last = last;
  end

  assign out_empty = !valid_r;
  assign take      = valid_r && out_pop;
  assign cmd_pop   = !cmd_empty && (!valid_r || (take && last));

  always_comb begin
    work_nxt  = work_r;
    valid_nxt = valid_r;
    if (cmd_pop) begin
      work_nxt  = cmd;
      valid_nxt = 1'b1;
    end else if (take) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else if (work_r.tabs != '0) begin
        work_nxt.tabs = work_r.tabs - CNT_W'(1);
      end else begin
        work_nxt.blanks = work_r.blanks - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/btc_checker.sv =====
`default_nettype none
module btc_checker import btc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_full,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire btc_out_t          out_item
);

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("stalled output item changed");

  a_run_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_item.last |-> out_item.out_byte == CH_TAB
                                     || out_item.out_byte == CH_BLANK)
    else $error("non-final byte is neither tab nor blank");

  a_no_tab_after_blank: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_item.last && out_item.out_byte == CH_BLANK
    |=> !out_empty && out_item.out_byte != CH_TAB)
    else $error("tab follows a pending blank");

endmodule

bind blank_run_to_tab_compressor btc_checker u_btc_checker (.*);
`default_nettype wire

// ===== tb/tb_blank_run_to_tab_compressor.sv =====
`default_nettype none
module tb_blank_run_to_tab_compressor;
  import btc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SEGMENTS    = 8;
  localparam int SEG_ITEMS   = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  btc_in_t           in_item = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  btc_out_t          out_item;
  logic              cfg_we = 1'b0;
  logic [MASK_W-1:0] cfg_data = '0;

  blank_run_to_tab_compressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // stimulus and expectations
  btc_in_t  feed_q[$];
  btc_out_t want_q[$];

  // entab predictor state
  logic [MASK_W-1:0] stop_mask = TAB_STOP_RESET;
  int                col = 0;
  int                tabs_held = 0;
  int                blanks_held = 0;

  int bad_count = 0;
  int cycle_count = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit push_taken = 1'b0;

  function automatic bit is_stop(int p);
    return (p < COLUMN_LIMIT) && stop_mask[p];
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    btc_out_t r;
    r.out_byte = b;
    r.last     = 1'b0;
    want_q.push_back(r);
  endfunction

  function automatic void emit_run(bit with_blanks);
    repeat (tabs_held) emit_byte(CH_TAB);
    tabs_held = 0;
    if (with_blanks) begin
      repeat (blanks_held) emit_byte(CH_BLANK);
    end
    blanks_held = 0;
  endfunction

  function automatic void entab_predict(btc_in_t it);
    int       base;
    int       s;
    btc_out_t tail;
    base = want_q.size();
    if (it.op == OP_FLUSH) begin
      emit_run(1'b1);
      col = 0;
    end else if (it.data_byte == CH_BLANK && col + 1 < COLUMN_LIMIT) begin
      if (is_stop(col + 1)) begin
        tabs_held++;
        blanks_held = 0;
      end else begin
        blanks_held++;
      end
      col++;
    end else if (it.data_byte == CH_TAB) begin
      emit_run(1'b0);
      emit_byte(CH_TAB);
      s = col + 1;
      while (s < COLUMN_LIMIT && !is_stop(s)) s++;
      col = (s < COLUMN_LIMIT) ? s : COLUMN_LIMIT;
    end else begin
      emit_run(1'b1);
      emit_byte(it.data_byte);
      if (it.data_byte == CH_NEWLINE) col = 0;
      else col = (col >= COLUMN_LIMIT) ? COLUMN_LIMIT : col + 1;
    end
    if (want_q.size() > base) begin
      tail = want_q[want_q.size() - 1];
      tail.last = 1'b1;
      want_q[want_q.size() - 1] = tail;
    end
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_push && !push_taken)) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item <= feed_q[0];
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) out_pop <= ($urandom_range(99) >= recv_stall);
  end

  // monitor, scoreboard and acceptance
  always @(posedge clk) begin
    btc_out_t want;
    push_taken = 1'b0;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        if (out_pop && !out_empty) begin
          if (want_q.size() == 0) begin
            $error("unexpected item: out_byte %02h last %0b", out_item.out_byte, out_item.last);
            bad_count++;
          end else begin
            want = want_q.pop_front();
            if (out_item.out_byte !== want.out_byte) begin
              $error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
              bad_count++;
            end
            if (out_item.last !== want.last) begin
              $error("last: expected %0b, got %0b", want.last, out_item.last);
              bad_count++;
            end
          end
        end
        if (in_push && !in_full) begin
          entab_predict(in_item);
          void'(feed_q.pop_front());
          push_taken = 1'b1;
        end
      end
    end
  end

  function automatic void queue_item(btc_op_t op, logic [7:0] b);
    btc_in_t it;
    it.op        = op;
    it.data_byte = b;
    feed_q.push_back(it);
  endfunction

  // text-like traffic: blank runs, tabs, line ends, other bytes, occasional flush
  function automatic int queue_random();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 45) begin
      n = $urandom_range(1, 8);
      repeat (n) queue_item(OP_TEXT, CH_BLANK);
      return n;
    end
    if (r < 55) queue_item(OP_TEXT, CH_TAB);
    else if (r < 62) queue_item(OP_TEXT, CH_NEWLINE);
    else if (r < 65) queue_item(OP_FLUSH, 8'($urandom_range(255)));
    else if (r < 85) queue_item(OP_TEXT, 8'($urandom_range(33, 126)));
    else queue_item(OP_TEXT, 8'($urandom_range(255)));
    return 1;
  endfunction

  task automatic drain();
    while (feed_q.size() != 0 || in_push || want_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_stops(logic [MASK_W-1:0] m);
    @(negedge clk);
    cfg_data  <= m;
    cfg_we    <= 1'b1;
    stop_mask = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [MASK_W-1:0] masks[SEGMENTS];
    int                n;
    masks[0] = '0;
    masks[1] = '1;
    masks[2] = {$urandom(), $urandom()};
    masks[3] = 64'hFFFF_FFFF_0000_0000;
    masks[4] = 64'h0101_0101_0101_0100;
    masks[5] = {$urandom(), $urandom()};
    masks[6] = TAB_STOP_RESET;
    masks[7] = 64'h0000_0000_8000_0001;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset stops every 4th column
    queue_item(OP_TEXT, 8'h61);
    repeat (3) queue_item(OP_TEXT, CH_BLANK);
    queue_item(OP_TEXT, 8'h62);
    queue_item(OP_TEXT, CH_BLANK);
    queue_item(OP_TEXT, CH_TAB);
    queue_item(OP_TEXT, CH_BLANK);
    queue_item(OP_TEXT, CH_NEWLINE);
    queue_item(OP_TEXT, CH_BLANK);
    queue_item(OP_FLUSH, CH_BLANK);
    queue_item(OP_FLUSH, 8'hFF);
    queue_item(OP_TEXT, 8'hFF);
    queue_item(OP_TEXT, 8'h00);
    queue_item(OP_TEXT, CH_NEWLINE);
    repeat (8) queue_item(OP_TEXT, CH_TAB);
    repeat (2) queue_item(OP_TEXT, CH_BLANK);
    queue_item(OP_TEXT, CH_NEWLINE);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_stops(masks[seg]);
      case (seg % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 45; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 45; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      n = 0;
      while (n < SEG_ITEMS / 2) n += queue_random();
      // hold the sender until every result is back
      drain();
      while (n < SEG_ITEMS) n += queue_random();
      drain();
    end

    repeat (20) @(negedge clk);
    if (bad_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/btc_pkg.sv
hw/rtl/btc_front.sv
hw/rtl/btc_fifo.sv
hw/rtl/btc_back.sv
hw/rtl/blank_run_to_tab_compressor.sv
hw/rtl/btc_checker.sv
tb/tb_blank_run_to_tab_compressor.sv
